// ===== rtl/core/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and the log2 table for the thin plate spline core.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int COORD_W   = 16;
  localparam int WEIGHT_W  = 32;
  localparam int VALUE_W   = 32;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int TERM_W    = 38;
  localparam int ACC_W     = 48;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_CONST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_Y     = 2'd3;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 7'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [26:0] INV16PI_Q32 = 27'd85445660;
  localparam logic [33:0] EPS_Q28     = 34'd32;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [WEIGHT_W-1:0] w;
  } point_t;

  typedef struct packed {
    logic term_valid;
    logic busy;
  } green_status_t;

  // log2(1 + i/16) in Q16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] t;
    case (i)
      5'd0:    t = 17'd0;
      5'd1:    t = 17'd5732;
      5'd2:    t = 17'd11136;
      5'd3:    t = 17'd16248;
      5'd4:    t = 17'd21098;
      5'd5:    t = 17'd25711;
      5'd6:    t = 17'd30109;
      5'd7:    t = 17'd34312;
      5'd8:    t = 17'd38336;
      5'd9:    t = 17'd42196;
      5'd10:   t = 17'd45904;
      5'd11:   t = 17'd49472;
      5'd12:   t = 17'd52911;
      5'd13:   t = 17'd56229;
      5'd14:   t = 17'd59434;
      5'd15:   t = 17'd62534;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/tps_cell.sv =====
// ----------------------------------------------------------------------------
// tps_cell
// One control point slot of the rotating point ring.
// ----------------------------------------------------------------------------
module tps_cell (
  input  logic            clk,
  input  logic            load,
  input  tps_pkg::point_t load_pt,
  input  logic            shift,
  input  tps_pkg::point_t shift_in,
  output tps_pkg::point_t pt
);

  always_ff @(posedge clk) begin
    if (load) begin
      pt <= load_pt;
    end else if (shift) begin
      pt <= shift_in;
    end
  end

endmodule

// ===== rtl/core/tps_green.sv =====
// ----------------------------------------------------------------------------
// tps_green
// Pipelined kernel term: weight * r2*ln(r2)/(16pi) for one point per cycle.
// ----------------------------------------------------------------------------
module tps_green (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [tps_pkg::COORD_W-1:0] qx,
  input  logic signed [tps_pkg::COORD_W-1:0] qy,
  input  tps_pkg::point_t                    pt,
  output tps_pkg::green_status_t             status,
  output logic signed [tps_pkg::TERM_W-1:0]  term
);

  localparam int NST = 12;

  logic [NST-1:0] v;

  logic signed [16:0] dx1, dy1;
  logic signed [31:0] w1, w2, w3, w4, w5, w6, w7, w8, w9, w10;
  logic signed [33:0] sqx2, sqy2;
  logic [33:0] r3, r4, r5, r6, r7, r8;
  logic [5:0]  p4, p5, p6, p_c;
  logic        s4, s5, s6, s7, s8, s9, s10;
  logic [40:0] m_c;
  logic [3:0]  idx5;
  logic [15:0] fr5;
  logic [16:0] t0_c, t1_c, t06;
  logic [28:0] prod6;
  logic [16:0] f_c;
  logic signed [7:0]  e_c;
  logic signed [23:0] l7;
  logic signed [54:0] lp8;
  logic signed [59:0] rl9;
  logic signed [61:0] hg10;
  logic signed [29:0] g_c;
  logic signed [61:0] wg11;

  always_comb begin
    p_c = 6'd0;
    for (int b = 0; b < 34; b++) begin
      if (r3[b]) begin
        p_c = 6'(b);
      end
    end
    m_c  = {7'b0, r4} << (6'd40 - p4);
    t0_c = tps_pkg::log2_tab({1'b0, idx5});
    t1_c = tps_pkg::log2_tab({1'b0, idx5} + 5'd1);
    f_c  = t06 + {4'b0, prod6[28:16]};
    e_c  = $signed({2'b0, p6}) - 8'sd28;
    g_c  = s10 ? 30'sd0 : hg10[61:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    dx1  <= {qx[15], qx} - {pt.x[15], pt.x};
    dy1  <= {qy[15], qy} - {pt.y[15], pt.y};
    w1   <= pt.w;
    sqx2 <= dx1 * dx1;
    sqy2 <= dy1 * dy1;
    w2   <= w1;
    r3   <= $unsigned(sqx2) + $unsigned(sqy2);
    w3   <= w2;
    r4   <= r3;
    p4   <= p_c;
    s4   <= r3 < tps_pkg::EPS_Q28;
    w4   <= w3;
    idx5 <= m_c[39:36];
    fr5  <= m_c[35:20];
    r5   <= r4;
    p5   <= p4;
    s5   <= s4;
    w5   <= w4;
    t06  <= t0_c;
    prod6 <= {12'b0, t1_c - t0_c} * {13'b0, fr5};
    r6   <= r5;
    p6   <= p5;
    s6   <= s5;
    w6   <= w5;
    l7   <= $signed({e_c, 16'b0}) + $signed({7'b0, f_c});
    r7   <= r6;
    s7   <= s6;
    w7   <= w6;
    lp8  <= l7 * $signed({1'b0, tps_pkg::LN2_Q30});
    r8   <= r7;
    s8   <= s7;
    w8   <= w7;
    rl9  <= $signed({1'b0, r8}) * $signed(lp8[54:30]);
    s9   <= s8;
    w9   <= w8;
    hg10 <= $signed(rl9[53:20]) * $signed({1'b0, tps_pkg::INV16PI_Q32});
    s10  <= s9;
    w10  <= w9;
    wg11 <= w10 * g_c;
    term <= wg11[61:24];
  end

  assign status.term_valid = v[NST-1];
  assign status.busy       = |v;

endmodule

// ===== rtl/core/thin_plate_spline_evaluate.sv =====
// ----------------------------------------------------------------------------
// thin_plate_spline_evaluate
// 2-D thin plate spline evaluator with a rotating ring of control points.
// ----------------------------------------------------------------------------
// A load word writes one control point into its ring slot. An evaluate word
// passes through the affine states (ST_AFF, then ST_SUM), one full revolution
// of the point ring (one point into the kernel pipeline per cycle), a drain
// of the 12-stage kernel pipeline (ST_DRAIN), and ST_DONE for the saturating
// output. One word is worked on at a time; a finished result waits in the
// output register while the next word is taken.
module thin_plate_spline_evaluate #(
  parameter int MAX_POINTS = tps_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tps_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [tps_pkg::IDX_W-1:0]            point_index,
  input  logic signed [tps_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [tps_pkg::COORD_W-1:0]   coord_y,
  input  logic signed [tps_pkg::WEIGHT_W-1:0]  weight,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tps_pkg::VALUE_W-1:0]   value,
  output logic                                 saturated
);

  localparam int KW  = $clog2(MAX_POINTS + 1);
  localparam int ACW = tps_pkg::ACC_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AFF   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic signed [ACW-1:0] VMAX = $signed({{(ACW-32){1'b0}}, 32'h7FFFFFFF});
  localparam logic signed [ACW-1:0] VMIN = $signed({{(ACW-32){1'b1}}, 32'h80000000});

  logic [2:0] state;
  logic [tps_pkg::CNT_W-1:0] point_count;
  logic signed [31:0] affine_const, affine_x, affine_y;
  logic signed [tps_pkg::COORD_W-1:0] qx, qy;
  logic signed [47:0] aff_px, aff_py;
  logic signed [ACW-1:0] acc;
  logic [KW-1:0] k, n_use;
  logic accept, shift, issue, out_free;

  tps_pkg::point_t load_pt;
  tps_pkg::point_t ring [MAX_POINTS];
  tps_pkg::green_status_t gstat;
  logic signed [tps_pkg::TERM_W-1:0] term;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;
  assign shift    = state == ST_RUN;
  assign issue    = shift && (k < n_use);
  assign out_free = !out_valid || out_ready;
  assign load_pt  = '{x: coord_x, y: coord_y, w: weight};

  always_comb begin
    if (int'(point_count) > MAX_POINTS) begin
      n_use = KW'(MAX_POINTS);
    end else begin
      n_use = KW'(point_count);
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
    tps_cell u_cell (
      .clk     (clk),
      .load    (accept && req_type == tps_pkg::REQ_LOAD && int'(point_index) == i),
      .load_pt (load_pt),
      .shift   (shift),
      .shift_in(ring[(i + 1) % MAX_POINTS]),
      .pt      (ring[i])
    );
  end

  tps_green u_green (
    .clk     (clk),
    .rst     (rst),
    .in_valid(issue),
    .qx      (qx),
    .qy      (qy),
    .pt      (ring[0]),
    .status  (gstat),
    .term    (term)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= tps_pkg::POINT_COUNT_RST;
      affine_const <= '0;
      affine_x     <= '0;
      affine_y     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tps_pkg::REG_POINT_COUNT:  point_count  <= cfg_data[tps_pkg::CNT_W-1:0];
        tps_pkg::REG_AFFINE_CONST: affine_const <= $signed(cfg_data);
        tps_pkg::REG_AFFINE_X:     affine_x     <= $signed(cfg_data);
        tps_pkg::REG_AFFINE_Y:     affine_y     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && req_type == tps_pkg::REQ_EVAL) begin
            state <= ST_AFF;
          end
        end
        ST_AFF: state <= ST_SUM;
        ST_SUM: begin
          k     <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          k <= k + 1'b1;
          if (k == KW'(MAX_POINTS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!gstat.busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= coord_x;
      qy <= coord_y;
    end
    aff_px <= affine_x * qx;
    aff_py <= affine_y * qy;
    if (state == ST_SUM) begin
      acc <= ACW'(affine_const) + ACW'(aff_px >>> 14) + ACW'(aff_py >>> 14);
    end else if (gstat.term_valid) begin
      acc <= acc + ACW'(term);
    end
    if (state == ST_DONE && out_free) begin
      if (acc > VMAX) begin
        value     <= 32'sh7FFFFFFF;
        saturated <= 1'b1;
      end else if (acc < VMIN) begin
        value     <= $signed(32'h80000000);
        saturated <= 1'b1;
      end else begin
        value     <= acc[31:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule
